FILE: sv/tis_pkg.sv
// Shared types and constants for the trapezoid integrator of x*x.
// No dependencies; compile first.
package tis_pkg;

  // Field widths of the request and result channels.
  localparam int unsigned BoundW      = 16;
  localparam int unsigned StepFieldW  = 16;
  localparam int unsigned AreaW       = 38;
  localparam int unsigned ErrW        = 2;

  // Step count mask width: default and the widest value supported.
  localparam int unsigned StepCountBitsDef = 16;
  localparam int unsigned MaxStepBits      = 24;

  // Datapath widths.
  localparam int unsigned XW     = 32;            // sample point, signed Q16.16
  localparam int unsigned ProdW  = 2 * XW;        // multiplier output
  localparam int unsigned FracSh = 24;            // x*x Q32.32 -> Q32.8
  localparam int unsigned FW     = ProdW - FracSh; // sample value width
  localparam int unsigned WW     = 57;            // doubled weighted sum
  localparam int unsigned WHiW   = WW - XW;       // upper slice of the sum
  localparam int unsigned DivSteps = XW;          // quotient bits of h
  localparam int unsigned CntW   = $clog2(DivSteps + 1);
  localparam int unsigned StepW  = 4;             // microcode address

  typedef enum logic [ErrW-1:0] {
    ERR_NONE       = 2'd0,
    ERR_ZERO_STEPS = 2'd1,
    ERR_BAD_ORDER  = 2'd2
  } err_e;

  // Control word fields.
  typedef enum logic [2:0] {
    X_HOLD, X_LOAD_A, X_LOAD_B, X_A_PLUS_H, X_ADD_H
  } x_sel_e;

  typedef enum logic [1:0] {
    MUL_NONE, MUL_SQUARE, MUL_W_LO, MUL_W_HI
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_NONE, ACC_CLEAR, ACC_ADD1, ACC_ADD2
  } acc_op_e;

  typedef enum logic [1:0] {
    I_HOLD, I_ONE, I_INC
  } i_op_e;

  typedef enum logic [2:0] {
    COND_NEVER, COND_ALWAYS, COND_IN_XFER, COND_BAD, COND_DIV_LAST,
    COND_I_EQ_N, COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    x_sel_e           x_sel;
    mul_sel_e         mul_sel;
    acc_op_e          acc_op;
    i_op_e            i_op;
    logic             take_in;
    logic             check;     // classify request, start the divider
    logic             div_step;
    logic             tmp_ld;
    logic             res_ld;
    logic             push;
    cond_e            cond;
    logic             hold;      // stay on this step while cond is false
    logic [StepW-1:0] target;
  } ctrl_t;

endpackage

FILE: sv/tis_in_if.sv
// Request channel: bounds and step count with valid/ready.
// Depends on tis_pkg.
interface tis_in_if;
  import tis_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [BoundW-1:0]   lower_bound;
  logic signed [BoundW-1:0]   upper_bound;
  logic [StepFieldW-1:0]      step_count;

  modport source (output valid, lower_bound, upper_bound, step_count, input ready);
  modport sink   (input valid, lower_bound, upper_bound, step_count, output ready);
endinterface

FILE: sv/tis_out_if.sv
// Result channel: area and error code with valid/ready.
// Depends on tis_pkg.
interface tis_out_if;
  import tis_pkg::*;

  logic             valid;
  logic             ready;
  logic [AreaW-1:0] area;
  logic [ErrW-1:0]  error_code;

  modport source (output valid, area, error_code, input ready);
  modport sink   (input valid, area, error_code, output ready);
endinterface

FILE: sv/trapezoid_integrate_square.sv
// Trapezoidal-rule integral of x*x, run by a microcode table over one datapath.
// An error request skips the divider and the sample loop and goes from the check
// step straight to completion. A new request is taken only in the idle step, so
// one request is in flight at a time. The work is set by the 32-step restoring
// divider and one square-and-accumulate per step on the shared 32x32 multiplier.
// Reset clears the step counter and the result valid flag.
// Depends on tis_pkg, tis_in_if, tis_out_if.
module trapezoid_integrate_square #(
  parameter int unsigned STEP_COUNT_BITS = tis_pkg::StepCountBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  tis_in_if.sink   in_i,
  tis_out_if.source out_o
);
  import tis_pkg::*;

  localparam int unsigned NW = STEP_COUNT_BITS;

  // Microcode addresses.
  localparam logic [StepW-1:0] S_IDLE  = 4'd0;
  localparam logic [StepW-1:0] S_CHECK = 4'd1;
  localparam logic [StepW-1:0] S_DIV   = 4'd2;
  localparam logic [StepW-1:0] S_SQA   = 4'd3;
  localparam logic [StepW-1:0] S_SQB   = 4'd4;
  localparam logic [StepW-1:0] S_ACCB  = 4'd5;
  localparam logic [StepW-1:0] S_LOOP  = 4'd6;
  localparam logic [StepW-1:0] S_MULLO = 4'd7;
  localparam logic [StepW-1:0] S_MULHI = 4'd8;
  localparam logic [StepW-1:0] S_SUM   = 4'd9;
  localparam logic [StepW-1:0] S_DONE  = 4'd10;

  localparam logic [AreaW-1:0] AreaMax = {AreaW{1'b1}};

  function automatic ctrl_t ucode(input logic [StepW-1:0] s);
    ctrl_t c;
    c.x_sel    = X_HOLD;
    c.mul_sel  = MUL_NONE;
    c.acc_op   = ACC_NONE;
    c.i_op     = I_HOLD;
    c.take_in  = 1'b0;
    c.check    = 1'b0;
    c.div_step = 1'b0;
    c.tmp_ld   = 1'b0;
    c.res_ld   = 1'b0;
    c.push     = 1'b0;
    c.cond     = COND_NEVER;
    c.hold     = 1'b0;
    c.target   = S_IDLE;
    unique case (s)
      S_IDLE: begin
        c.take_in = 1'b1;
        c.cond    = COND_IN_XFER;
        c.hold    = 1'b1;
        c.target  = S_CHECK;
      end
      S_CHECK: begin
        c.check  = 1'b1;
        c.x_sel  = X_LOAD_A;
        c.cond   = COND_BAD;
        c.target = S_DONE;
      end
      S_DIV: begin
        c.div_step = 1'b1;
        c.cond     = COND_DIV_LAST;
        c.hold     = 1'b1;
        c.target   = S_SQA;
      end
      S_SQA: begin
        c.mul_sel = MUL_SQUARE;
        c.x_sel   = X_LOAD_B;
        c.acc_op  = ACC_CLEAR;
      end
      S_SQB: begin
        c.mul_sel = MUL_SQUARE;
        c.acc_op  = ACC_ADD1;
        c.x_sel   = X_A_PLUS_H;
        c.i_op    = I_ONE;
      end
      S_ACCB: begin
        c.acc_op = ACC_ADD1;
      end
      S_LOOP: begin
        c.mul_sel = MUL_SQUARE;
        c.x_sel   = X_ADD_H;
        c.i_op    = I_INC;
        c.acc_op  = ACC_ADD2;
        c.cond    = COND_I_EQ_N;
        c.hold    = 1'b1;
        c.target  = S_MULLO;
      end
      S_MULLO: begin
        c.mul_sel = MUL_W_LO;
      end
      S_MULHI: begin
        c.mul_sel = MUL_W_HI;
        c.tmp_ld  = 1'b1;
      end
      S_SUM: begin
        c.res_ld = 1'b1;
      end
      S_DONE: begin
        c.push   = 1'b1;
        c.cond   = COND_OUT_FREE;
        c.hold   = 1'b1;
        c.target = S_IDLE;
      end
      default: begin
        c.cond   = COND_ALWAYS;
        c.target = S_IDLE;
      end
    endcase
    return c;
  endfunction

  // Sequencer and control state.
  logic [StepW-1:0] step_q, step_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             pend_q;
  logic             out_valid_q;
  ctrl_t            cw;

  // Datapath registers.
  logic signed [BoundW-1:0] a_q, b_q;
  logic [NW-1:0]            n_q, i_q;
  logic [NW-1:0]            rem_q;
  logic [XW-1:0]            h_q;        // dividend shifts out, quotient shifts in
  logic [XW-1:0]            x_q;
  logic [ProdW-1:0]         prod_q;
  logic [XW-1:0]            tmp_q;
  logic [WW-1:0]            w_q;
  logic [AreaW-1:0]         res_area_q, out_area_q;
  err_e                     res_err_q, out_err_q;

  logic                     in_xfer, out_free, bad_order, zero_n, cond_hit;
  logic [MaxStepBits-1:0]   step_ext;
  logic signed [BoundW:0]   diff;
  logic [NW:0]              trial;
  logic                     q_bit;
  logic [XW-1:0]            a24, b24, mag, op_a, op_b;
  logic [FW-1:0]            f_val;
  logic [ProdW:0]           total;

  assign cw       = ucode(step_q);
  assign in_xfer  = in_i.valid && cw.take_in;
  assign out_free = !out_valid_q || out_o.ready;

  assign bad_order = (a_q > b_q);
  assign zero_n    = (n_q == '0);
  assign diff      = {b_q[BoundW-1], b_q} - {a_q[BoundW-1], a_q};
  assign a24       = {a_q, 16'h0000};
  assign b24       = {b_q, 16'h0000};
  assign step_ext  = {{(MaxStepBits - StepFieldW){1'b0}}, in_i.step_count};

  // Restoring division step.
  assign trial = {rem_q, h_q[XW-1]};
  assign q_bit = (trial >= {1'b0, n_q});

  // Shared multiplier operand selection.
  assign mag = x_q[XW-1] ? (~x_q + 1'b1) : x_q;
  always_comb begin
    unique case (cw.mul_sel)
      MUL_W_LO: begin
        op_a = w_q[XW-1:0];
        op_b = h_q;
      end
      MUL_W_HI: begin
        op_a = {{(XW - WHiW){1'b0}}, w_q[WW-1:XW]};
        op_b = h_q;
      end
      default: begin
        op_a = mag;
        op_b = mag;
      end
    endcase
  end

  assign f_val = prod_q[ProdW-1:FracSh];
  assign total = {1'b0, prod_q} + {{(ProdW + 1 - XW){1'b0}}, tmp_q};

  always_comb begin
    unique case (cw.cond)
      COND_NEVER:    cond_hit = 1'b0;
      COND_ALWAYS:   cond_hit = 1'b1;
      COND_IN_XFER:  cond_hit = in_xfer;
      COND_BAD:      cond_hit = bad_order || zero_n;
      COND_DIV_LAST: cond_hit = (cnt_q == CntW'(1));
      COND_I_EQ_N:   cond_hit = (i_q == n_q);
      COND_OUT_FREE: cond_hit = out_free;
      default:       cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (cond_hit) begin
      step_d = cw.target;
    end else if (cw.hold) begin
      step_d = step_q;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cw.check) begin
      cnt_d = CntW'(DivSteps);
    end else if (cw.div_step) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= S_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      cnt_q  <= cnt_d;
      pend_q <= (cw.acc_op == ACC_ADD2);
      if (cw.push && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      a_q <= in_i.lower_bound;
      b_q <= in_i.upper_bound;
      n_q <= step_ext[NW-1:0];
    end

    if (cw.check) begin
      rem_q      <= '0;
      h_q        <= {diff[BoundW-1:0], 16'h0000};
      res_area_q <= '0;
      if (bad_order) begin
        res_err_q <= ERR_BAD_ORDER;
      end else if (zero_n) begin
        res_err_q <= ERR_ZERO_STEPS;
      end else begin
        res_err_q <= ERR_NONE;
      end
    end else if (cw.div_step) begin
      rem_q <= q_bit ? NW'(trial - {1'b0, n_q}) : trial[NW-1:0];
      h_q   <= {h_q[XW-2:0], q_bit};
    end

    unique case (cw.x_sel)
      X_LOAD_A:   x_q <= a24;
      X_LOAD_B:   x_q <= b24;
      X_A_PLUS_H: x_q <= a24 + h_q;
      X_ADD_H:    x_q <= x_q + h_q;
      default:    x_q <= x_q;
    endcase

    unique case (cw.i_op)
      I_ONE:   i_q <= NW'(1);
      I_INC:   i_q <= i_q + 1'b1;
      default: i_q <= i_q;
    endcase

    if (cw.mul_sel != MUL_NONE) begin
      prod_q <= op_a * op_b;
    end

    // Ends weigh once, interior points twice; the sum stays doubled.
    unique case (cw.acc_op)
      ACC_CLEAR: w_q <= '0;
      ACC_ADD1:  w_q <= w_q + {{(WW - FW){1'b0}}, f_val};
      ACC_ADD2: begin
        if (pend_q) begin
          w_q <= w_q + {{(WW - FW - 1){1'b0}}, f_val, 1'b0};
        end
      end
      default:   w_q <= w_q;
    endcase

    if (cw.tmp_ld) begin
      tmp_q <= prod_q[ProdW-1:XW];
    end

    // total is floor(h*w / 2^32); halve it and saturate.
    if (cw.res_ld) begin
      if (total[ProdW:AreaW+1] != '0) begin
        res_area_q <= AreaMax;
      end else begin
        res_area_q <= total[AreaW:1];
      end
    end

    if (cw.push && out_free) begin
      out_area_q <= res_area_q;
      out_err_q  <= res_err_q;
    end
  end

  assign in_i.ready       = cw.take_in;
  assign out_o.valid      = out_valid_q;
  assign out_o.area       = out_area_q;
  assign out_o.error_code = out_err_q;

  // A result appears only from the completion step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step_q == S_DONE))
    else $error("result valid rose outside completion step");

  // A rejected request carries zero area.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_err_q != ERR_NONE)) |-> (out_area_q == '0))
    else $error("error result with nonzero area");

  // The divider remainder stays below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == S_DIV) |-> (rem_q < n_q))
    else $error("divider remainder out of range");

  // The sample index runs from one up to the step count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == S_LOOP) |-> ((i_q != '0) && (i_q <= n_q)))
    else $error("sample index out of range");

endmodule

FILE: verif/trapezoid_integrate_square_test.sv
// Self-checking bench for trapezoid_integrate_square: random and directed requests,
// results scored against an in-bench fixed-point model of the trapezoidal rule on x*x.
// Depends on tis_pkg, tis_in_if, tis_out_if and the block itself.
module trapezoid_integrate_square_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tis_pkg::*;

  typedef longint unsigned u64_t;

  localparam int unsigned StepBits   = StepCountBitsDef;
  localparam logic [95:0] AreaMax    = (96'd1 << AreaW) - 96'd1;
  localparam int unsigned RandCount  = 100;
  localparam int unsigned HoldCycles = 3000;
  localparam int unsigned MaxGap     = 80;
  localparam int unsigned DrainTail  = 100;

  typedef struct {
    logic signed [BoundW-1:0] lo;
    logic signed [BoundW-1:0] hi;
    logic [StepFieldW-1:0]    steps;
    int unsigned              gap_pct;
    bit                       drain_first;
  } bounds_req_t;

  typedef struct {
    logic [AreaW-1:0] area;
    err_e             err;
  } area_res_t;

  logic clk;
  logic rst_n;

  tis_in_if  req_if ();
  tis_out_if res_if ();

  trapezoid_integrate_square uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  bounds_req_t pending_q[$];
  area_res_t   expected_area_q[$];

  int unsigned n_sent, n_recv, n_fail;
  int unsigned n_ok, n_zero, n_order, n_sat, n_flat;
  int unsigned hold_after;
  longint unsigned cycle_limit, cycles, budget;

  // x in signed Q16.16 -> x*x in unsigned Q32.8
  function automatic u64_t square_q24(input longint x);
    u64_t mag;
    mag = (x < 0) ? u64_t'(-x) : u64_t'(x);
    return (mag * mag) >> 24;
  endfunction

  function automatic area_res_t integrate_square(input logic signed [BoundW-1:0] lo,
                                                 input logic signed [BoundW-1:0] hi,
                                                 input logic [StepFieldW-1:0] steps);
    area_res_t   r;
    u64_t        n, h, w, i;
    longint      base, span;
    logic [95:0] prod;
    n = u64_t'(steps) & ((64'd1 << StepBits) - 64'd1);
    r.area = '0;
    r.err  = ERR_NONE;
    if (lo > hi) begin
      r.err = ERR_BAD_ORDER;
    end else if (n == 0) begin
      r.err = ERR_ZERO_STEPS;
    end else begin
      span = longint'(hi) - longint'(lo);
      h    = u64_t'(span << 16) / n;
      base = longint'(lo) * 65536;
      // end points once, interior points twice: the sum is kept doubled
      w = square_q24(base) + square_q24(longint'(hi) * 65536);
      for (i = 1; i < n; i++) begin
        w += 2 * square_q24(base + longint'(i * h));
      end
      prod = (96'(w) * 96'(h)) >> 33;
      r.area = (prod > AreaMax) ? AreaMax[AreaW-1:0] : prod[AreaW-1:0];
    end
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned draw_gap(input int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(20, MaxGap);
    return $urandom_range(1, 4);
  endfunction

  function automatic int unsigned sink_stall_pct(input int unsigned recv);
    case ((recv / 25) % 4)
      0: return 0;
      1: return 15;
      2: return 40;
      default: return 5;
    endcase
  endfunction

  task automatic queue_request(input logic signed [BoundW-1:0] lo,
                               input logic signed [BoundW-1:0] hi,
                               input logic [StepFieldW-1:0] steps,
                               input int unsigned gap_pct, input bit drain_first);
    bounds_req_t q;
    q.lo = lo;
    q.hi = hi;
    q.steps = steps;
    q.gap_pct = gap_pct;
    q.drain_first = drain_first;
    pending_q.push_back(q);
    budget += u64_t'(steps) + 41 + 2 * MaxGap;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Request driver: one transfer per handshake, random idle between requests.
  int unsigned src_idle;
  bit          offering;
  bounds_req_t next_req;
  area_res_t   pred;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_if.valid       <= 1'b0;
      req_if.lower_bound <= '0;
      req_if.upper_bound <= '0;
      req_if.step_count  <= '0;
      src_idle = 0;
    end else begin
      offering = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        pred = integrate_square(req_if.lower_bound, req_if.upper_bound, req_if.step_count);
        expected_area_q.push_back(pred);
        n_sent++;
        case (pred.err)
          ERR_ZERO_STEPS: n_zero++;
          ERR_BAD_ORDER:  n_order++;
          default: begin
            n_ok++;
            if (pred.area == AreaMax[AreaW-1:0]) n_sat++;
            if (pred.area == '0) n_flat++;
          end
        endcase
        offering = 1'b0;
      end
      if (!offering) begin
        if (src_idle != 0) begin
          src_idle--;
        end else if (pending_q.size() != 0 &&
                     !(pending_q[0].drain_first && expected_area_q.size() != 0)) begin
          next_req = pending_q.pop_front();
          req_if.lower_bound <= next_req.lo;
          req_if.upper_bound <= next_req.hi;
          req_if.step_count  <= next_req.steps;
          src_idle = draw_gap(next_req.gap_pct);
          offering = 1'b1;
        end
      end
      req_if.valid <= offering;
    end
  end

  // Result monitor and scoreboard; also owns the receiver's stalls.
  int unsigned snk_stall, hold_left;
  bit          rdy;
  area_res_t   want;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      snk_stall = 0;
      hold_left = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        n_recv++;
        if (expected_area_q.size() == 0) begin
          $display("%0t: unexpected result area %0h error_code %0d",
                   $realtime, res_if.area, res_if.error_code);
          n_fail++;
        end else begin
          want = expected_area_q.pop_front();
          if (res_if.area !== want.area) begin
            $display("%0t: area mismatch: expected %0h got %0h",
                     $realtime, want.area, res_if.area);
            n_fail++;
          end
          if (res_if.error_code !== want.err) begin
            $display("%0t: error_code mismatch: expected %0d got %0d",
                     $realtime, want.err, res_if.error_code);
            n_fail++;
          end
        end
        // back-pressure long enough to stall the request side
        if (n_recv == hold_after) hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (snk_stall != 0) begin
        snk_stall--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        snk_stall = draw_gap(sink_stall_pct(n_recv));
      end
      res_if.ready <= rdy;
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      cycles = 0;
    end else begin
      cycles++;
      if (cycles > cycle_limit) begin
        $display("timeout after %0d cycles, %0d of %0d results seen",
                 cycles, n_recv, n_sent);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  logic signed [BoundW-1:0] r_lo, r_hi, r_tmp;
  logic [StepFieldW-1:0]    r_steps;
  int unsigned              kind, pct, n_dir;
  int                       wide;

  initial begin
    req_if.valid       = 1'b0;
    req_if.lower_bound = '0;
    req_if.upper_bound = '0;
    req_if.step_count  = '0;
    res_if.ready       = 1'b0;
    rst_n              = 1'b0;
    budget             = 0;
    cycle_limit        = 64'hFFFF_FFFF;

    // directed: extremes, each error path, equal bounds, sign crossings
    queue_request(16'sd0, 16'sd0, 16'd1, 0, 1'b0);
    queue_request(-16'sd32768, 16'sd32767, 16'd1, 0, 1'b0);
    queue_request(-16'sd32768, 16'sd32767, 16'd2, 0, 1'b0);
    queue_request(-16'sd32768, 16'sd32767, 16'hFFFF, 0, 1'b0);
    queue_request(16'sd1, 16'sd0, 16'd5, 0, 1'b0);
    queue_request(16'sd32767, -16'sd32768, 16'd0, 0, 1'b0);
    queue_request(16'sd0, 16'sd256, 16'd0, 0, 1'b0);
    queue_request(-16'sd32768, -16'sd32768, 16'd3, 0, 1'b0);
    queue_request(16'sd32767, 16'sd32767, 16'd9, 0, 1'b0);
    queue_request(-16'sd512, -16'sd256, 16'd7, 0, 1'b0);
    queue_request(-16'sd300, 16'sd400, 16'd13, 0, 1'b0);
    queue_request(-16'sd1, 16'sd0, 16'd1, 0, 1'b0);
    queue_request(16'sd0, 16'sd1, 16'd64, 0, 1'b0);
    queue_request(16'sd0, 16'sd32767, 16'd255, 0, 1'b0);
    queue_request(-16'sd32768, 16'sd0, 16'd100, 0, 1'b0);
    queue_request(16'sh5555, 16'sh7FFF, 16'd21, 0, 1'b0);
    queue_request(-16'sd21846, 16'sh5555, 16'd40, 0, 1'b0);
    queue_request(16'sd256, -16'sd256, 16'd0, 0, 1'b0);
    queue_request(-16'sd32767, 16'sd32767, 16'd1000, 0, 1'b0);
    n_dir = pending_q.size();
    hold_after = n_dir + 10;

    for (int k = 0; k < RandCount; k++) begin
      pct  = (k < 30) ? 25 : (k < 60) ? 0 : 40;
      kind = $urandom_range(99);
      r_lo = BoundW'($urandom);
      r_hi = BoundW'($urandom);
      if (r_lo > r_hi) begin
        r_tmp = r_lo;
        r_lo  = r_hi;
        r_hi  = r_tmp;
      end
      if (kind < 6) begin
        // reversed bounds
        if (r_lo == r_hi) r_lo = r_hi - 16'sd1;
        if (r_lo == 16'sh7FFF) r_hi = 16'sh8000;
        else begin
          r_tmp = r_lo;
          r_lo  = r_hi;
          r_hi  = r_tmp;
        end
      end else if (kind < 9) begin
        r_hi = r_lo;
      end else if (kind >= 14 && kind < 45) begin
        wide = int'(r_lo) + int'($urandom_range(0, 511));
        r_hi = (wide > 32767) ? 16'sh7FFF : BoundW'(wide);
      end
      if (kind >= 9 && kind < 14) r_steps = '0;
      else if (k == 40 || k == 85) r_steps = StepFieldW'($urandom_range(32768, 65535));
      else if ($urandom_range(9) < 8) r_steps = StepFieldW'($urandom_range(1, 32));
      else r_steps = StepFieldW'($urandom_range(33, 1024));
      queue_request(r_lo, r_hi, r_steps, pct, (k == 30) || (k == 60));
    end
    cycle_limit = 4 * budget + 4 * HoldCycles + 10000;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // offering covers the edge where the driver has popped but not yet raised valid
    while (pending_q.size() != 0 || req_if.valid || offering) @(posedge clk);
    while (expected_area_q.size() != 0) @(posedge clk);
    repeat (DrainTail) @(posedge clk);

    if (n_recv != n_sent) begin
      $display("%0t: result count mismatch: expected %0d got %0d",
               $realtime, n_sent, n_recv);
    end
    $display("%0d requests (%0d directed) and %0d results: %0d integrals, %0d zero-step,",
             n_sent, n_dir, n_recv, n_ok, n_zero);
    $display("%0d reversed-bound, %0d saturated, %0d zero-area; %0d cycles",
             n_order, n_sat, n_flat, cycles);
    if (n_fail == 0 && n_recv == n_sent) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: trapezoid_integrate_square.f
sv/tis_pkg.sv
sv/tis_in_if.sv
sv/tis_out_if.sv
sv/trapezoid_integrate_square.sv
verif/trapezoid_integrate_square_test.sv
